@@ hw/rtl/sha512_pkg.sv @@
// ----------------------------------------------------------------------------
// sha512_pkg
// Round constants, initial hash values and the sigma functions of SHA-512.
// ----------------------------------------------------------------------------
`default_nettype none

package sha512_pkg;

  localparam int unsigned ROUNDS      = 80;
  localparam int unsigned BLOCK_BYTES = 128;
  localparam int unsigned BLOCK_WORDS = BLOCK_BYTES / 8;

  typedef logic [63:0] word_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    case (i)
      3'd0:    init_hash = 64'h6A09E667F3BCC908;
      3'd1:    init_hash = 64'hBB67AE8584CAA73B;
      3'd2:    init_hash = 64'h3C6EF372FE94F82B;
      3'd3:    init_hash = 64'hA54FF53A5F1D36F1;
      3'd4:    init_hash = 64'h510E527FADE682D1;
      3'd5:    init_hash = 64'h9B05688C2B3E6C1F;
      3'd6:    init_hash = 64'h1F83D9ABFB41BD6B;
      default: init_hash = 64'h5BE0CD19137E2179;
    endcase
  endfunction

  function automatic word_t round_const(input logic [6:0] t);
    case (t)
      7'd0:  round_const = 64'h428A2F98D728AE22;
      7'd1:  round_const = 64'h7137449123EF65CD;
      7'd2:  round_const = 64'hB5C0FBCFEC4D3B2F;
      7'd3:  round_const = 64'hE9B5DBA58189DBBC;
      7'd4:  round_const = 64'h3956C25BF348B538;
      7'd5:  round_const = 64'h59F111F1B605D019;
      7'd6:  round_const = 64'h923F82A4AF194F9B;
      7'd7:  round_const = 64'hAB1C5ED5DA6D8118;
      7'd8:  round_const = 64'hD807AA98A3030242;
      7'd9:  round_const = 64'h12835B0145706FBE;
      7'd10: round_const = 64'h243185BE4EE4B28C;
      7'd11: round_const = 64'h550C7DC3D5FFB4E2;
      7'd12: round_const = 64'h72BE5D74F27B896F;
      7'd13: round_const = 64'h80DEB1FE3B1696B1;
      7'd14: round_const = 64'h9BDC06A725C71235;
      7'd15: round_const = 64'hC19BF174CF692694;
      7'd16: round_const = 64'hE49B69C19EF14AD2;
      7'd17: round_const = 64'hEFBE4786384F25E3;
      7'd18: round_const = 64'h0FC19DC68B8CD5B5;
      7'd19: round_const = 64'h240CA1CC77AC9C65;
      7'd20: round_const = 64'h2DE92C6F592B0275;
      7'd21: round_const = 64'h4A7484AA6EA6E483;
      7'd22: round_const = 64'h5CB0A9DCBD41FBD4;
      7'd23: round_const = 64'h76F988DA831153B5;
      7'd24: round_const = 64'h983E5152EE66DFAB;
      7'd25: round_const = 64'hA831C66D2DB43210;
      7'd26: round_const = 64'hB00327C898FB213F;
      7'd27: round_const = 64'hBF597FC7BEEF0EE4;
      7'd28: round_const = 64'hC6E00BF33DA88FC2;
      7'd29: round_const = 64'hD5A79147930AA725;
      7'd30: round_const = 64'h06CA6351E003826F;
      7'd31: round_const = 64'h142929670A0E6E70;
      7'd32: round_const = 64'h27B70A8546D22FFC;
      7'd33: round_const = 64'h2E1B21385C26C926;
      7'd34: round_const = 64'h4D2C6DFC5AC42AED;
      7'd35: round_const = 64'h53380D139D95B3DF;
      7'd36: round_const = 64'h650A73548BAF63DE;
      7'd37: round_const = 64'h766A0ABB3C77B2A8;
      7'd38: round_const = 64'h81C2C92E47EDAEE6;
      7'd39: round_const = 64'h92722C851482353B;
      7'd40: round_const = 64'hA2BFE8A14CF10364;
      7'd41: round_const = 64'hA81A664BBC423001;
      7'd42: round_const = 64'hC24B8B70D0F89791;
      7'd43: round_const = 64'hC76C51A30654BE30;
      7'd44: round_const = 64'hD192E819D6EF5218;
      7'd45: round_const = 64'hD69906245565A910;
      7'd46: round_const = 64'hF40E35855771202A;
      7'd47: round_const = 64'h106AA07032BBD1B8;
      7'd48: round_const = 64'h19A4C116B8D2D0C8;
      7'd49: round_const = 64'h1E376C085141AB53;
      7'd50: round_const = 64'h2748774CDF8EEB99;
      7'd51: round_const = 64'h34B0BCB5E19B48A8;
      7'd52: round_const = 64'h391C0CB3C5C95A63;
      7'd53: round_const = 64'h4ED8AA4AE3418ACB;
      7'd54: round_const = 64'h5B9CCA4F7763E373;
      7'd55: round_const = 64'h682E6FF3D6B2B8A3;
      7'd56: round_const = 64'h748F82EE5DEFB2FC;
      7'd57: round_const = 64'h78A5636F43172F60;
      7'd58: round_const = 64'h84C87814A1F0AB72;
      7'd59: round_const = 64'h8CC702081A6439EC;
      7'd60: round_const = 64'h90BEFFFA23631E28;
      7'd61: round_const = 64'hA4506CEBDE82BDE9;
      7'd62: round_const = 64'hBEF9A3F7B2C67915;
      7'd63: round_const = 64'hC67178F2E372532B;
      7'd64: round_const = 64'hCA273ECEEA26619C;
      7'd65: round_const = 64'hD186B8C721C0C207;
      7'd66: round_const = 64'hEADA7DD6CDE0EB1E;
      7'd67: round_const = 64'hF57D4F7FEE6ED178;
      7'd68: round_const = 64'h06F067AA72176FBA;
      7'd69: round_const = 64'h0A637DC5A2C898A6;
      7'd70: round_const = 64'h113F9804BEF90DAE;
      7'd71: round_const = 64'h1B710B35131C471B;
      7'd72: round_const = 64'h28DB77F523047D84;
      7'd73: round_const = 64'h32CAAB7B40C72493;
      7'd74: round_const = 64'h3C9EBE0A15C9BEBC;
      7'd75: round_const = 64'h431D67C49C100D4C;
      7'd76: round_const = 64'h4CC5D4BECB3E42B6;
      7'd77: round_const = 64'h597F299CFC657E2A;
      7'd78: round_const = 64'h5FCB6FAB3AD6FAEC;
      7'd79: round_const = 64'h6C44198C4A475817;
      default: round_const = 64'h0;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sha512_hash.sv @@
// ----------------------------------------------------------------------------
// sha512_hash
// SHA-512 of a byte message streamed as big-endian 64-bit words.
// ----------------------------------------------------------------------------
// Message words come in on the msg channel, eight bytes each, first byte in
// bits 63:56. bytes_valid counts the leading valid bytes and matters only on
// the word that carries end_of_message (values above 8 count as 8); an empty
// message is a single item with zero bytes and the end mark. Each word is
// stored into the 16-entry schedule memory. Every 16th word starts a
// compression: S_CINIT loads the working variables, each of the 80 rounds
// runs through S_RA and S_RB (the schedule memory has two read ports and a
// round needs four schedule words), and S_CADD adds them into the chaining
// value. msg_ready stays low during a compression. After the end mark the
// block writes the padding words at one per cycle, compresses the last one
// or two blocks, then presents the eight digest words on the dig channel,
// index 0 first, last_word high on index 7. The hash then returns to its
// initial values and a new message may start.
// ----------------------------------------------------------------------------
`default_nettype none

module sha512_hash (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        msg_valid,
  output logic             msg_ready,
  input  wire logic [63:0] message_word,
  input  wire logic [3:0]  bytes_valid,
  input  wire logic        end_of_message,
  output logic             dig_valid,
  input  wire logic        dig_ready,
  output logic [63:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;  // take message words
  localparam logic [2:0] S_PAD   = 3'd1;  // write padding words
  localparam logic [2:0] S_CINIT = 3'd2;  // load working variables
  localparam logic [2:0] S_RA    = 3'd3;  // first half of a round
  localparam logic [2:0] S_RB    = 3'd4;  // second half: compute and write back
  localparam logic [2:0] S_CADD  = 3'd5;  // fold into chaining value
  localparam logic [2:0] S_OUT   = 3'd6;  // hand out digest words

  localparam logic [6:0] LAST_ROUND = 7'(sha512_pkg::ROUNDS - 1);

  logic [2:0]  state;
  logic [3:0]  cnt;        // words held in the current block
  logic [63:0] byte_len;
  logic        pend80;     // marker byte still to be written as its own word
  logic        ending;     // end mark seen, padding in progress
  logic        len_here;   // length word goes into slot 15 of this block
  logic [6:0]  round;
  logic [2:0]  out_idx;

  sha512_pkg::word_t chain [0:7];
  sha512_pkg::word_t wv    [0:7];
  sha512_pkg::word_t w16;
  sha512_pkg::word_t w15;

  // Schedule memory: one write port, two registered read ports. A round
  // writes its own slot in S_RB while the reads for the next round target
  // other slots, so no forwarding is needed.
  sha512_pkg::word_t sched [0:15];
  sha512_pkg::word_t rd_a;
  sha512_pkg::word_t rd_b;
  logic [3:0]        addr_a;
  logic [3:0]        addr_b;
  logic              we;
  logic [3:0]        waddr;
  sha512_pkg::word_t wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      sched[waddr] <= wdata;
    end
    rd_a <= sched[addr_a];
    rd_b <= sched[addr_b];
  end

  // final-word shaping: keep the valid bytes, set the marker after them
  logic [3:0]        nb;
  sha512_pkg::word_t keep_mask;
  sha512_pkg::word_t marked_word;
  sha512_pkg::word_t len_word;

  always_comb begin
    nb          = (bytes_valid > 4'd8) ? 4'd8 : bytes_valid;
    keep_mask   = ~64'd0 << (7'd64 - {nb, 3'b000});
    marked_word = (message_word & keep_mask) | (64'h80 << (6'd56 - {nb[2:0], 3'b000}));
    len_word    = {byte_len[60:0], 3'b000};
  end

  // round datapath
  logic [3:0]        slot;
  sha512_pkg::word_t w_cur;
  sha512_pkg::word_t t1;
  sha512_pkg::word_t t2;

  always_comb begin
    slot  = round[3:0];
    w_cur = (round < 7'd16) ? w16
          : sha512_pkg::small_sigma1(rd_b) + rd_a + sha512_pkg::small_sigma0(w15) + w16;
    t1 = wv[7] + sha512_pkg::big_sigma1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
       + sha512_pkg::round_const(round) + w_cur;
    t2 = sha512_pkg::big_sigma0(wv[0])
       + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  // memory port control
  always_comb begin
    we     = 1'b0;
    waddr  = cnt;
    wdata  = 64'd0;
    addr_a = slot;
    addr_b = slot + 4'd1;
    case (state)
      S_IDLE: begin
        we    = msg_valid;
        wdata = (end_of_message && nb != 4'd8) ? marked_word : message_word;
      end
      S_PAD: begin
        we    = 1'b1;
        wdata = pend80 ? 64'h8000_0000_0000_0000
              : ((cnt == 4'd15 && len_here) ? len_word : 64'd0);
      end
      S_CINIT: begin
        addr_a = 4'd0;
        addr_b = 4'd1;
      end
      S_RA: begin
        addr_a = slot + 4'd9;
        addr_b = slot + 4'd14;
      end
      S_RB: begin
        we     = (round >= 7'd16);
        waddr  = slot;
        wdata  = w_cur;
        addr_a = slot + 4'd1;
        addr_b = slot + 4'd2;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign msg_ready   = (state == S_IDLE);
  assign dig_valid   = (state == S_OUT);
  assign digest_word = chain[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= 4'd0;
      byte_len <= 64'd0;
      pend80   <= 1'b0;
      ending   <= 1'b0;
      len_here <= 1'b0;
      round    <= 7'd0;
      out_idx  <= 3'd0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= sha512_pkg::init_hash(3'(i));
        wv[i]    <= 64'd0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (msg_valid) begin
            cnt <= cnt + 4'd1;
            if (!end_of_message) begin
              byte_len <= byte_len + 64'd8;
              state    <= (cnt == 4'd15) ? S_CINIT : S_IDLE;
            end else begin
              byte_len <= byte_len + {60'd0, nb};
              ending   <= 1'b1;
              pend80   <= (nb == 4'd8);
              // marker in slot 13 or lower leaves room for the length
              len_here <= (nb != 4'd8) && (cnt <= 4'd13);
              state    <= (cnt == 4'd15) ? S_CINIT : S_PAD;
            end
          end
        end
        S_PAD: begin
          cnt <= cnt + 4'd1;
          if (pend80) begin
            pend80   <= 1'b0;
            len_here <= (cnt <= 4'd13);
          end
          if (cnt == 4'd15) begin
            state <= S_CINIT;
          end
        end
        S_CINIT: begin
          for (int i = 0; i < 8; i++) begin
            wv[i] <= chain[i];
          end
          round <= 7'd0;
          state <= S_RA;
        end
        S_RA: begin
          w16   <= rd_a;
          w15   <= rd_b;
          state <= S_RB;
        end
        S_RB: begin
          wv[7] <= wv[6];
          wv[6] <= wv[5];
          wv[5] <= wv[4];
          wv[4] <= wv[3] + t1;
          wv[3] <= wv[2];
          wv[2] <= wv[1];
          wv[1] <= wv[0];
          wv[0] <= t1 + t2;
          if (round == LAST_ROUND) begin
            round <= 7'd0;
            state <= S_CADD;
          end else begin
            round <= round + 7'd1;
            state <= S_RA;
          end
        end
        S_CADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + wv[i];
          end
          if (!ending) begin
            state <= S_IDLE;
          end else if (len_here && !pend80) begin
            state <= S_OUT;
          end else begin
            // marker landed too late: one more block carries the length
            if (!pend80) begin
              len_here <= 1'b1;
            end
            state <= S_PAD;
          end
        end
        S_OUT: begin
          if (dig_ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                chain[i] <= sha512_pkg::init_hash(3'(i));
              end
              byte_len <= 64'd0;
              cnt      <= 4'd0;
              ending   <= 1'b0;
              len_here <= 1'b0;
              state    <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
